>>> src/etacc_pkg.sv
// Shared types, constants and the log2 fraction table for the entropy term accumulator.
package etacc_pkg;

  localparam int FRAC_BITS       = 16;
  localparam int SUM_BITS        = 26;
  localparam int LOG_TABLE_DEPTH = 256;  // power of two

  localparam int LOG_DEPTH_BITS = $clog2(LOG_TABLE_DEPTH);
  localparam int IDX_W          = LOG_DEPTH_BITS + 1;
  localparam int LEAD_W         = $clog2(FRAC_BITS);
  localparam int CHAR_W         = $clog2(FRAC_BITS + 1);
  localparam int NL_W           = CHAR_W + FRAC_BITS;
  localparam int PROD_W         = FRAC_BITS + NL_W + 1;

  localparam logic [FRAC_BITS:0]    ONE_Q   = (FRAC_BITS + 1)'(1) << FRAC_BITS;
  localparam logic [PROD_W-1:0]     HALF_Q  = PROD_W'(1) << (FRAC_BITS - 1);
  localparam logic [SUM_BITS-1:0]   SUM_MAX = '1;

  typedef struct packed {
    logic [FRAC_BITS:0] prob;
    logic               last;
  } sample_t;

  typedef struct packed {
    logic [FRAC_BITS-1:0] term;
    logic [SUM_BITS-1:0]  running_sum;
    logic                 set_done;
    logic                 saturated;
  } result_t;

  // log2(1 + i/DEPTH) in Q0.FRAC_BITS; the entry for i = DEPTH (exactly 1.0) is
  // handled outside the table.
  typedef logic [FRAC_BITS-1:0] log_tab_t [0:LOG_TABLE_DEPTH-1];

  // Bit-by-bit squaring method, evaluated at elaboration only.
  function automatic log_tab_t build_log_tab();
    log_tab_t             tab;
    logic [63:0]          x;
    logic [FRAC_BITS-1:0] r;
    for (int i = 0; i < LOG_TABLE_DEPTH; i++) begin
      x = (64'd1 << 30) + ((64'(i) << 30) / LOG_TABLE_DEPTH);
      r = '0;
      for (int k = 0; k < FRAC_BITS; k++) begin
        x = (x * x) >> 30;
        r = r << 1;
        if (x >= (64'd1 << 31)) begin
          x    = x >> 1;
          r[0] = 1'b1;
        end
      end
      tab[i] = r;
    end
    return tab;
  endfunction

  localparam log_tab_t LOG_TAB = build_log_tab();

endpackage

>>> src/entropy_term_accumulator.sv
// Entropy term accumulator: -p*log2(p) per probability and per-set running sum.
//
//  channel  | direction | payload   | transaction when
//  ---------+-----------+-----------+----------------------------------
//  sample   | in        | sample_t  | sample_valid && sample_ready
//  result   | out       | result_t  | result_valid && result_ready
//
//  One transaction per cycle sustained while result_ready holds high; a sample is
//  taken into the input register and its result then into the result register,
//  from which it can be taken on the result channel.
//  Leading-one search, table log2, one multiply and the sum update sit in the
//  single logic level between the two registers.
//  rst (synchronous) empties both stages and clears the sum and overflow flag.
//  A stalled result holds the result register; the input register still takes
//  a sample while it is empty, after which sample_ready follows result_ready.
module entropy_term_accumulator (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_ready,
  input  etacc_pkg::sample_t sample,
  output logic              result_valid,
  input  logic              result_ready,
  output etacc_pkg::result_t result
);
  import etacc_pkg::*;

  // input stage
  logic    s1_valid;
  sample_t s1;

  // set state
  logic [SUM_BITS-1:0] acc;
  logic                ovf;

  // datapath
  logic [LEAD_W-1:0]    lead;
  logic [FRAC_BITS-1:0] norm;
  logic [30:0]          frac;
  logic [IDX_W-1:0]     idx;
  logic [FRAC_BITS:0]   log_frac;
  logic [CHAR_W-1:0]    int_part;
  logic [NL_W-1:0]      nl;
  logic [PROD_W-1:0]    prod;
  logic [FRAC_BITS-1:0] term;
  logic [SUM_BITS:0]    sum_wide;
  logic [SUM_BITS-1:0]  acc_next;
  logic                 ovf_next;
  result_t              result_next;

  logic adv;  // result register may load

  assign adv          = !result_valid || result_ready;
  assign sample_ready = !s1_valid || adv;

  always_comb begin
    // leading one of p, then normalise so that the mantissa fraction is on top
    lead = '0;
    for (int b = 0; b < FRAC_BITS; b++) begin
      if (s1.prob[b]) lead = LEAD_W'(b);
    end
    norm = s1.prob[FRAC_BITS-1:0] << (LEAD_W'(FRAC_BITS - 1) - lead);
    frac = {norm[FRAC_BITS-2:0], {(32 - FRAC_BITS){1'b0}}};

    // rounded table index, may reach DEPTH
    idx = {1'b0, frac[30 -: LOG_DEPTH_BITS]} + IDX_W'(frac[30 - LOG_DEPTH_BITS]);
    if (idx[LOG_DEPTH_BITS]) begin
      log_frac = ONE_Q;
    end else begin
      log_frac = {1'b0, LOG_TAB[idx[LOG_DEPTH_BITS-1:0]]};
    end

    // -log2 p = (F - m) - log2(1 + f)
    int_part = CHAR_W'(FRAC_BITS) - CHAR_W'(lead);
    nl       = {int_part, {FRAC_BITS{1'b0}}} - NL_W'(log_frac);
    prod     = PROD_W'(s1.prob[FRAC_BITS-1:0]) * PROD_W'(nl) + HALF_Q;

    if (prod[PROD_W-1:2*FRAC_BITS] != '0) begin
      term = '1;
    end else begin
      term = prod[2*FRAC_BITS-1:FRAC_BITS];
    end
    // zero is the limit of -p log p; one or above gives nothing
    if (s1.prob == '0 || s1.prob[FRAC_BITS]) begin
      term = '0;
    end

    sum_wide = {1'b0, acc} + (SUM_BITS + 1)'(term);
    if (sum_wide[SUM_BITS]) begin
      acc_next = SUM_MAX;
      ovf_next = 1'b1;
    end else begin
      acc_next = sum_wide[SUM_BITS-1:0];
      ovf_next = ovf;
    end

    result_next.term        = term;
    result_next.running_sum = acc_next;
    result_next.set_done    = s1.last;
    result_next.saturated   = ovf_next;
  end

  // control and set state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
      acc          <= '0;
      ovf          <= 1'b0;
    end else begin
      if (sample_ready) begin
        s1_valid <= sample_valid;
      end
      if (adv) begin
        result_valid <= s1_valid;
      end
      if (adv && s1_valid) begin
        // outputs carry the closing values; the set then starts afresh
        acc <= s1.last ? '0 : acc_next;
        ovf <= s1.last ? 1'b0 : ovf_next;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (sample_ready) begin
      s1 <= sample;
    end
    if (adv && s1_valid) begin
      result <= result_next;
    end
  end

  // a saturated set pins the sum at its top until the set closes
  a_sat_pins_sum: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.saturated |-> result.running_sum == SUM_MAX)
    else $error("saturated flag without a full-scale sum");

  // a closing transaction leaves the set state clear
  a_close_clears: assert property (@(posedge clk) disable iff (rst)
    adv && s1_valid && s1.last |=> acc == '0 && !ovf)
    else $error("set state not cleared after set close");

  // a zero probability contributes nothing
  a_zero_term: assert property (@(posedge clk) disable iff (rst)
    adv && s1_valid && s1.prob == '0 |=> result.term == '0)
    else $error("non-zero term for zero probability");

endmodule

>>> dv/tb.sv
// Self-checking testbench for the entropy term accumulator: driver, monitor and predictor.
`timescale 1ns / 100ps

module tb;
  import etacc_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;  // cycles without any transaction
  localparam int DRAIN_CYCLES   = 20;    // pipeline is two stages deep
  localparam int PRESSURE_HOLD  = 60;    // long receiver stall, fills the pipeline
  localparam int PRESSURE_AT    = 40;    // result count that triggers it
  localparam int RANDOM_ITEMS   = 580;
  localparam int LONG_SET_LEN   = 1000;  // near-1/e terms, drives the sum well up its range
  localparam int QUIET_TAIL     = 300;   // last stretch runs without idling

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    sample_valid = 1'b0;
  logic    sample_ready;
  sample_t sample = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;

  entropy_term_accumulator u_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always #1 clk = ~clk;

  // Stimulus and scoreboard storage
  sample_t sample_queue[$];
  result_t predicted_results[$];

  // Predictor state: mirrors the block's accumulator and overflow flag
  logic [SUM_BITS-1:0] sum_acc = '0;
  logic                sum_clipped = 1'b0;
  logic [FRAC_BITS:0]  log_frac [0:LOG_TABLE_DEPTH];

  int   mismatch_count = 0;
  int   results_seen = 0;
  int   samples_sent = 0;
  logic allow_idle = 1'b0;

  // log2(1 + i/DEPTH) in Q0.FRAC_BITS by repeated squaring; last entry is exactly 1.0
  function automatic logic [FRAC_BITS:0] mantissa_log2(int i);
    logic [63:0]        x;
    logic [FRAC_BITS:0] bits;
    if (i == LOG_TABLE_DEPTH) return ONE_Q;
    x    = (64'd1 << 30) + ((64'(i) << 30) / LOG_TABLE_DEPTH);
    bits = '0;
    repeat (FRAC_BITS) begin
      x    = (x * x) >> 30;
      bits = {bits[FRAC_BITS-1:0], x[31]};
      if (x[31]) x = x >> 1;
    end
    return bits;
  endfunction

  // -p*log2(p) in Q0.FRAC_BITS; zero for p = 0 and for p at or above one
  function automatic logic [FRAC_BITS-1:0] entropy_term(logic [FRAC_BITS:0] p);
    int          lead;
    logic [63:0] frac, idx, neg_log, prod;
    if (p == 0 || p >= ONE_Q) return '0;
    lead = 0;
    for (int b = 0; b < FRAC_BITS; b++)
      if (p[b]) lead = b;
    frac = (64'(p) << (31 - lead)) - (64'd1 << 31);
    idx  = (frac * LOG_TABLE_DEPTH + (64'd1 << 30)) >> 31;
    if (idx > LOG_TABLE_DEPTH) idx = LOG_TABLE_DEPTH;
    neg_log = (64'(FRAC_BITS - lead) << FRAC_BITS) - 64'(log_frac[idx]);
    prod    = (64'(p) * neg_log + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    if (prod > (64'd1 << FRAC_BITS) - 1) prod = (64'd1 << FRAC_BITS) - 1;
    return prod[FRAC_BITS-1:0];
  endfunction

  // Advances the predicted sum and returns the result this sample should give
  function automatic result_t predict_result(sample_t s);
    result_t           r;
    logic [SUM_BITS:0] total;
    r.term = entropy_term(s.prob);
    total  = {1'b0, sum_acc} + (SUM_BITS + 1)'(r.term);
    if (total[SUM_BITS]) begin
      total       = {1'b0, SUM_MAX};
      sum_clipped = 1'b1;
    end
    sum_acc       = total[SUM_BITS-1:0];
    r.running_sum = sum_acc;
    r.set_done    = s.last;
    r.saturated   = sum_clipped;
    if (s.last) begin
      sum_acc     = '0;
      sum_clipped = 1'b0;
    end
    return r;
  endfunction

  function automatic void queue_sample(logic [FRAC_BITS:0] p, logic l);
    sample_t s;
    s.prob = p;
    s.last = l;
    sample_queue.push_back(s);
  endfunction

  // Mostly in-range probabilities, some above one, plus edges and small values
  function automatic logic [FRAC_BITS:0] random_prob();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return (FRAC_BITS + 1)'($urandom_range(0, 65536));
      5:             return (FRAC_BITS + 1)'($urandom_range(0, 2 * 65536 - 1));
      6:             return (FRAC_BITS + 1)'($urandom_range(0, 255));
      7: begin
        case ($urandom_range(0, 5))
          0:       return 0;
          1:       return 1;
          2:       return ONE_Q - 1;
          3:       return ONE_Q;
          4:       return ONE_Q + 1;
          default: return '1;
        endcase
      end
      8:       return (FRAC_BITS + 1)'($urandom_range(20000, 28000));
      default: return (FRAC_BITS + 1)'(1) << $urandom_range(0, FRAC_BITS);
    endcase
  endfunction

  // Driver: offers samples, predicts each accepted transaction
  always @(posedge clk) begin
    logic    accepted, next_valid;
    sample_t next_sample;
    int      gap;
    if (rst) begin
      sample_valid <= 1'b0;
      gap = 0;
    end else begin
      accepted    = sample_valid && sample_ready;
      next_valid  = sample_valid && !accepted;
      next_sample = sample;
      if (accepted) begin
        predicted_results.push_back(predict_result(sample));
        samples_sent++;
      end
      if (!next_valid) begin
        if (gap > 0) begin
          gap--;
        end else if (allow_idle && $urandom_range(0, 7) == 0) begin
          gap = $urandom_range(0, 7);
        end else if (sample_queue.size() != 0) begin
          next_valid  = 1'b1;
          next_sample = sample_queue.pop_front();
        end
      end
      sample_valid <= next_valid;
      sample       <= next_sample;
      // idling in alternating stretches, none at the tail
      allow_idle <= (sample_queue.size() > QUIET_TAIL) && (((samples_sent >> 8) % 4) != 3);
    end
  end

  // Monitor: takes results, compares with the oldest prediction
  always @(posedge clk) begin
    result_t want;
    int      stall;
    int      hold;
    logic    pressure_done;
    if (rst) begin
      result_ready <= 1'b0;
      stall = 0;
      hold = 0;
      pressure_done = 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        results_seen++;
        if (predicted_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: result with none expected, got %p", $time, result);
        end else begin
          want = predicted_results.pop_front();
          if (result !== want) begin
            mismatch_count++;
            $display("%0t: result %0d expected term=%0d sum=%0d done=%0b sat=%0b",
                     $time, results_seen, want.term, want.running_sum, want.set_done,
                     want.saturated);
            $display("%0t: result %0d got term=%0d sum=%0d done=%0b sat=%0b",
                     $time, results_seen, result.term, result.running_sum,
                     result.set_done, result.saturated);
          end
        end
      end
      // one long hold-off so the pipeline backs up into the sample side
      if (!pressure_done && results_seen >= PRESSURE_AT) begin
        pressure_done = 1'b1;
        hold = PRESSURE_HOLD;
      end
      if (hold > 0) begin
        hold--;
        result_ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        result_ready <= 1'b0;
      end else if (allow_idle && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(0, 7);
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  // Watchdog: run stops if no transaction moves for too long
  always @(posedge clk) begin
    int quiet;
    if (rst || (sample_valid && sample_ready) || (result_valid && result_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    int random_count;
    int set_len;

    for (int i = 0; i <= LOG_TABLE_DEPTH; i++)
      log_frac[i] = mantissa_log2(i);

    // Directed: zero, one, above one, extremes, powers of two, near 1/e
    queue_sample(0, 1'b1);
    queue_sample(ONE_Q, 1'b0);
    queue_sample(ONE_Q + 1, 1'b0);
    queue_sample('1, 1'b0);
    queue_sample(1, 1'b0);
    queue_sample(2, 1'b0);
    queue_sample(3, 1'b0);
    queue_sample(ONE_Q - 1, 1'b1);
    queue_sample(32768, 1'b0);
    queue_sample(16384, 1'b0);
    queue_sample(24109, 1'b0);
    queue_sample(256, 1'b0);
    queue_sample(43690, 1'b0);
    queue_sample(21845, 1'b0);
    queue_sample(1, 1'b1);
    queue_sample(ONE_Q, 1'b1);
    queue_sample(0, 1'b0);
    queue_sample(0, 1'b1);

    // One long set of large terms: the sum climbs through its upper bits
    for (int i = 0; i < LONG_SET_LEN; i++)
      queue_sample((FRAC_BITS + 1)'($urandom_range(20000, 28000)), i == LONG_SET_LEN - 1);
    // the set after a long one starts clean
    queue_sample(24109, 1'b1);

    // Random sets, mostly short, now and then long
    random_count = 0;
    while (random_count < RANDOM_ITEMS) begin
      set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 80) : $urandom_range(1, 12);
      for (int i = 0; i < set_len; i++)
        queue_sample(random_prob(), i == set_len - 1);
      random_count += set_len;
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (sample_queue.size() != 0 || sample_valid || predicted_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
